// ----- rtl/ilid_pkg.sv -----
// Shared types and constants for the indexed list insert/delete unit.
`default_nettype none

package ilid_pkg;

  // Field widths
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LEN_W  = 7;

  // Stream packing
  localparam int unsigned S_TDATA_W = 40;  // position, value, no fill bits
  localparam int unsigned S_PAD_W   = S_TDATA_W - POS_W - VAL_W;
  localparam int unsigned M_TDATA_W = 40;  // read_value, length, zero fill
  localparam int unsigned M_PAD_W   = M_TDATA_W - VAL_W - LEN_W;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_HEAD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INS_BEFORE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

  // Value returned by a read at an invalid position
  localparam logic [VAL_W-1:0] READ_MISS = '1;

  typedef enum logic [1:0] {
    RD_AT,     // element at the index
    RD_BELOW,  // element one below the index
    RD_ABOVE   // element one above the index
  } rd_sel_e;

  typedef enum logic {
    WR_MOVED,  // element just read, written at the index
    WR_NEW     // request value, written at the insert position
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    decide;
    logic    mem_rd;
    rd_sel_e rd_sel;
    logic    mem_wr;
    wr_sel_e wr_sel;
    logic    idx_dec;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } ilid_cmd_t;

  typedef struct packed {
    logic read_ok;
    logic ins_ok;
    logic del_ok;
    logic shr_more;
    logic shl_more;
    logic out_free;
  } ilid_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ilid_dp.sv -----
// Datapath of the indexed list unit: element memory, count, index and result register.
`default_nettype none

module ilid_dp import ilid_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned PW = (CW > 7) ? CW : 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ilid_cmd_t               cmd_i,
  output      ilid_stat_t              stat_o,
  input  wire logic [KIND_W-1:0]       req_kind_i,
  input  wire logic signed [POS_W-1:0] req_pos_i,
  input  wire logic [VAL_W-1:0]        req_value_i,
  input  wire logic                    m_tready_i,
  output      logic                    m_tvalid_o,
  output      logic [M_TDATA_W-1:0]    m_tdata_o,  // read_value[31:0], length[38:32], zero
  output      logic                    m_tuser_o   // accepted
);

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rdata_q;

  logic [KIND_W-1:0] kind_q;
  logic              neg_q;
  logic [6:0]        pos_q;
  logic [VAL_W-1:0]  value_q;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     ins_pos_q;
  logic              acc_q;
  logic [CW-1:0]     count_q, count_d;

  logic              m_valid_q, m_valid_d;
  logic [VAL_W-1:0]  m_rv_q;
  logic [LEN_W-1:0]  m_len_q;
  logic              m_acc_q;

  logic [PW-1:0]     pos_ext, cnt_ext;
  logic              full, pos_lt, pos_le;
  logic              read_ok, ins_ok, del_ok;
  logic [CW-1:0]     ins_tgt;
  logic [CW-1:0]     raddr_full, waddr_full;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  rv_next;

  // Request decode
  assign pos_ext = PW'(pos_q);
  assign cnt_ext = PW'(count_q);
  assign full    = count_q >= CW'(CAPACITY);
  assign pos_lt  = !neg_q && (pos_ext < cnt_ext);
  assign pos_le  = !neg_q && (pos_ext <= cnt_ext);

  assign read_ok = (kind_q == KIND_READ) && pos_lt;
  assign del_ok  = (kind_q == KIND_DELETE) && pos_lt;
  assign ins_ok  = !full && ((kind_q == KIND_INS_HEAD) || (kind_q == KIND_INS_TAIL) ||
                             ((kind_q == KIND_INS_BEFORE) && (neg_q || pos_le)));

  always_comb begin
    case (kind_q)
      KIND_INS_TAIL:   ins_tgt = count_q;
      KIND_INS_BEFORE: ins_tgt = neg_q ? '0 : CW'(pos_ext);
      default:         ins_tgt = '0;
    endcase
  end

  assign stat_o.read_ok  = read_ok;
  assign stat_o.ins_ok   = ins_ok;
  assign stat_o.del_ok   = del_ok;
  assign stat_o.shr_more = idx_q > ins_pos_q;
  assign stat_o.shl_more = ({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, count_q};
  assign stat_o.out_free = !m_valid_q || m_tready_i;

  // Request capture and index bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_kind_i;
      neg_q   <= req_pos_i[POS_W-1];
      pos_q   <= req_pos_i[6:0];
      value_q <= req_value_i;
    end
    if (cmd_i.decide) begin
      acc_q     <= read_ok || ins_ok || del_ok;
      ins_pos_q <= ins_tgt;
    end
    idx_q <= idx_d;
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.decide) begin
      idx_d = ins_ok ? count_q : CW'(pos_ext);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Element memory: one read or one write per cycle
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_BELOW: raddr_full = idx_q - CW'(1);
      RD_ABOVE: raddr_full = idx_q + CW'(1);
      default:  raddr_full = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_NEW: begin
        waddr_full = ins_pos_q;
        wdata      = value_q;
      end
      default: begin
        waddr_full = idx_q;
        wdata      = rdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[waddr_full[AW-1:0]] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[raddr_full[AW-1:0]];
    end
  end

  // Result register
  always_comb begin
    if (kind_q == KIND_READ) begin
      rv_next = acc_q ? rdata_q : READ_MISS;
    end else begin
      rv_next = '0;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_rv_q  <= rv_next;
      m_acc_q <= acc_q;
      m_len_q <= LEN_W'(cnt_ext);
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{M_PAD_W{1'b0}}, m_len_q, m_rv_q};
  assign m_tuser_o  = m_acc_q;

endmodule

`default_nettype wire

// ----- rtl/ilid_ctrl.sv -----
// Controller of the indexed list unit: sequences reads, shifts and writes per item.
`default_nettype none

module ilid_ctrl import ilid_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output      logic       s_tready_o,
  input  wire ilid_stat_t stat_i,
  output      ilid_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_SHR_RD = 4'd3;
  localparam logic [3:0] S_SHR_WR = 4'd4;
  localparam logic [3:0] S_INS_WR = 4'd5;
  localparam logic [3:0] S_SHL_RD = 4'd6;
  localparam logic [3:0] S_SHL_WR = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_AT;
    cmd_o.wr_sel = WR_MOVED;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.read_ok) begin
          state_d = S_READ;
        end else if (stat_i.ins_ok) begin
          state_d = S_SHR_RD;
        end else if (stat_i.del_ok) begin
          state_d = S_SHL_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_FINISH;
      end
      // Make room: move elements up one place, from the top down
      S_SHR_RD: begin
        if (stat_i.shr_more) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = RD_BELOW;
          state_d      = S_SHR_WR;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_SHR_WR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_SHR_RD;
      end
      S_INS_WR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_sel  = WR_NEW;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FINISH;
      end
      // Close the gap: move elements down one place, from the bottom up
      S_SHL_RD: begin
        if (stat_i.shl_more) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = RD_ABOVE;
          state_d      = S_SHL_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_SHL_WR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SHL_RD;
      end
      S_FINISH: begin
        // Hold the result until the output register is free
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/indexed_list_insert_delete_unit.sv -----
// Top level of the indexed list unit: stream ports, controller and datapath.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a single-port
// memory and answers one request per item: read at a position, insert at head,
// tail or before a position, or delete at a position. Every item gives exactly
// one result with the read value, an accepted flag and the new length (low 7
// bits). Items are handled one at a time. Once accepted, a request is decided:
// a read then does one memory read, a rejected request goes straight to the
// result, an insert moves the elements at and after its position up one place
// and writes the new value, and a delete moves those after it down one place.
// Each move is a memory read followed by a memory write. The next item is taken
// at the edge after the result has entered the output register, which may still
// be waiting on the sink; a stalled sink holds the finished result back and
// lengthens the item by the cycles of the stall. No clearing pass is run after
// reset.
`default_nettype none

module indexed_list_insert_delete_unit import ilid_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // position[7:0], value[39:8]
  input  wire logic [KIND_W-1:0]    s_axis_tuser_i,  // kind[2:0]
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output      logic [M_TDATA_W-1:0] m_axis_tdata_o,  // read_value[31:0], length[38:32], zero
  output      logic                 m_axis_tuser_o   // accepted
);

  ilid_cmd_t  cmd;
  ilid_stat_t stat;

  logic signed [POS_W-1:0] req_pos;
  logic [VAL_W-1:0]        req_value;

  assign req_pos   = s_axis_tdata_i[POS_W-1:0];
  assign req_value = s_axis_tdata_i[POS_W+VAL_W-1:POS_W];

  ilid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ilid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_kind_i  (s_axis_tuser_i),
    .req_pos_i   (req_pos),
    .req_value_i (req_value),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- rtl/ilid_checker.sv -----
// Port-level checks for the indexed list unit, bound to its top level.
`default_nettype none

module ilid_checker import ilid_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid_i,
  input wire logic                 s_axis_tready_o,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata_o,  // read_value[31:0], length[38:32], zero
  input wire logic                 m_axis_tuser_o   // accepted
);

  logic             in_acc, out_acc;
  logic [1:0]       pend_q, pend_d;
  logic             have_prev_q;
  logic [LEN_W-1:0] prev_len_q;
  logic [VAL_W-1:0] rv;
  logic [LEN_W-1:0] len;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign rv      = m_axis_tdata_o[VAL_W-1:0];
  assign len     = m_axis_tdata_o[VAL_W+LEN_W-1:VAL_W];

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      have_prev_q <= 1'b0;
      prev_len_q  <= '0;
    end else begin
      pend_q <= pend_d;
      if (out_acc) begin
        have_prev_q <= 1'b1;
        prev_len_q  <= len;
      end
    end
  end

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped before it was taken");

  // No result without an item behind it, and at most two items in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("result shown with no item outstanding");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items in flight");

  // A rejected request returns zero or the read-miss value
  a_reject_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> rv == '0 || rv == READ_MISS)
    else $error("rejected request with a stray read value");

  // The length moves by at most one from one result to the next
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_prev_q |->
      len == prev_len_q || len == prev_len_q + LEN_W'(1) || len + LEN_W'(1) == prev_len_q)
    else $error("length jumped by more than one");

endmodule

bind indexed_list_insert_delete_unit ilid_checker u_ilid_checker (.*);

`default_nettype wire

// ----- tb/indexed_list_checker.sv -----
`timescale 1ns / 100ps
// Checker for the indexed list unit: tracks the list contents, predicts each result, compares.
module indexed_list_checker import ilid_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,  // position[7:0], value[39:8]
  input  logic [KIND_W-1:0]    s_tuser_i,  // kind[2:0]
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,  // read_value[31:0], length[38:32], zero
  input  logic                 m_tuser_i,  // accepted
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   list_len_o
);

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             accepted;
    logic [LEN_W-1:0] length;
  } list_result_t;

  logic [VAL_W-1:0] elems[$];     // list contents, head first
  list_result_t     result_q[$];  // results still owed by the block
  int               fails = 0;

  function automatic list_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input logic signed [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] value);
    list_result_t res;
    int           idx;
    bit           full;
    res  = '0;
    idx  = pos;
    full = (elems.size() >= CAPACITY);
    case (kind)
      KIND_READ: begin
        if (idx >= 0 && idx < elems.size()) begin
          res.read_value = elems[idx];
          res.accepted   = 1'b1;
        end else begin
          res.read_value = READ_MISS;
        end
      end
      KIND_INS_HEAD: begin
        if (!full) begin
          elems.push_front(value);
          res.accepted = 1'b1;
        end
      end
      KIND_INS_TAIL: begin
        if (!full) begin
          elems.push_back(value);
          res.accepted = 1'b1;
        end
      end
      KIND_INS_BEFORE: begin
        // negative goes to the head, one past the end appends, beyond that is refused
        if (!full && idx < 0) begin
          elems.push_front(value);
          res.accepted = 1'b1;
        end else if (!full && idx <= elems.size()) begin
          elems.insert(idx, value);
          res.accepted = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (idx >= 0 && idx < elems.size()) begin
          elems.delete(idx);
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(elems.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      elems.delete();
      result_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.read_value = m_tdata_i[VAL_W-1:0];
        got.length     = m_tdata_i[VAL_W +: LEN_W];
        got.accepted   = m_tuser_i;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected item: read_value %0d accepted %b length %0d", $time,
                   $signed(got.read_value), got.accepted, got.length);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %0d actual %0d", $time,
                     $signed(want.read_value), $signed(got.read_value));
            fails++;
          end
          if (got.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %b actual %b", $time,
                     want.accepted, got.accepted);
            fails++;
          end
          if (got.length !== want.length) begin
            $display("%0t: length mismatch: expected %0d actual %0d", $time,
                     want.length, got.length);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        result_q.push_back(apply_request(s_tuser_i, s_tdata_i[POS_W-1:0],
                                         s_tdata_i[POS_W +: VAL_W]));
      end
    end
    fail_count_o <= fails;
    pending_o    <= result_q.size();
    list_len_o   <= elems.size();
  end

endmodule

// ----- tb/indexed_list_insert_delete_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the indexed list unit: clock, reset, stimulus, back-pressure and verdict.
module indexed_list_insert_delete_unit_tb;
  import ilid_pkg::*;

  localparam int unsigned CAPACITY        = 64;
  localparam int          ITEMS_PER_PHASE = 188;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          DRAIN_CYCLES    = 150;
  localparam int          STALL_LIMIT     = 4000;
  localparam int          KIND_MAX        = (1 << KIND_W) - 1;

  typedef enum int {MODE_FILL, MODE_DRAIN} list_mode_e;

  logic                 clk     = 1'b0;
  logic                 rst_n   = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0]    s_tuser = '0;
  logic                 s_ready;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  int fail_count;
  int pending_count;
  int list_len;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_go      = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  indexed_list_insert_delete_unit #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  indexed_list_checker #(
    .CAPACITY (CAPACITY)
  ) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .list_len_o   (list_len)
  );

  // Offer one request, idling first at the current rate; return at the edge it is taken.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= S_TDATA_W'({value, pos});
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // Result sink: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_ready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    list_mode_e        mode;
    int                turn_count;
    int                r;
    int                len;
    mode       = MODE_FILL;
    turn_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: misses, refused delete, tail insert that lands at the head
    send_request(KIND_READ,       8'd0,   32'h0000_0000);
    send_request(KIND_READ,       8'h80,  32'hFFFF_FFFF);
    send_request(KIND_DELETE,     8'd0,   32'h0000_0000);
    send_request(KIND_INS_TAIL,   8'd0,   32'h7FFF_FFFF);
    send_request(KIND_INS_HEAD,   8'd0,   32'h8000_0000);
    send_request(KIND_INS_BEFORE, 8'hFF,  32'hFFFF_FFFF);
    send_request(KIND_INS_BEFORE, 8'd3,   32'h0000_0000);
    send_request(KIND_INS_BEFORE, 8'd5,   32'hDEAD_BEEF);
    send_request(KIND_INS_BEFORE, 8'd127, 32'hDEAD_BEEF);
    send_request(KIND_INS_BEFORE, 8'd2,   32'h5A5A_A5A5);
    for (int i = 0; i < 5; i++) send_request(KIND_READ, POS_W'(i), 32'h0);
    send_request(KIND_READ,       8'd5,   32'h0000_0000);
    send_request(KIND_READ,       8'd127, 32'h0000_0000);
    send_request(KIND_DELETE,     8'd127, 32'h0000_0000);
    send_request(KIND_DELETE,     8'hFF,  32'h0000_0000);
    send_request(KIND_DELETE,     8'd4,   32'h0000_0000);
    send_request(KIND_DELETE,     8'd0,   32'h0000_0000);
    for (int k = KIND_DELETE + 1; k <= KIND_MAX; k++) begin
      send_request(KIND_W'(k), POS_W'($urandom), $urandom);
    end
    send_request(KIND_INS_TAIL,   8'd0,   32'h1234_5678);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 84; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 84; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == ITEMS_PER_PHASE / 2) hold_go = 1'b1;
        len = list_len;
        // linger a while at full and at empty before turning round
        if (mode == MODE_FILL && len >= CAPACITY) turn_count++;
        if (mode == MODE_DRAIN && len == 0) turn_count++;
        if (turn_count >= 8) begin
          mode       = (mode == MODE_FILL) ? MODE_DRAIN : MODE_FILL;
          turn_count = 0;
        end
        r = $urandom_range(99);
        if (mode == MODE_FILL) begin
          if (r < 25)      kind = KIND_INS_HEAD;
          else if (r < 50) kind = KIND_INS_TAIL;
          else if (r < 75) kind = KIND_INS_BEFORE;
          else if (r < 87) kind = KIND_READ;
          else if (r < 95) kind = KIND_DELETE;
          else             kind = KIND_W'($urandom_range(KIND_MAX));
        end else begin
          if (r < 55)      kind = KIND_DELETE;
          else if (r < 80) kind = KIND_READ;
          else if (r < 90) kind = KIND_W'($urandom_range(KIND_INS_HEAD, KIND_INS_BEFORE));
          else             kind = KIND_W'($urandom_range(KIND_MAX));
        end
        if ($urandom_range(99) < 80) begin
          if (kind == KIND_INS_BEFORE) pos = POS_W'($urandom_range(len));
          else                         pos = (len > 0) ? POS_W'($urandom_range(len - 1)) : '0;
        end else begin
          pos = POS_W'($urandom);
        end
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = '0;
            default: value = '1;
          endcase
        end else begin
          value = $urandom;
        end
        send_request(kind, pos, value);
      end
    end

    s_valid      <= 1'b0;
    rx_stall_pct  = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
